FILE: rtl/apss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apss_pkg: shared types and codes for the converter scan sequencer
// Item layouts, command codes, scan step codes and configuration indexes.
// ----------------------------------------------------------------------------
package apss_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_MAN_V_EN  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAN_V_VAL = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAN_C_EN  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MAN_C_VAL = 2'd3;

	localparam logic [1:0] CMD_NONE    = 2'd0;
	localparam logic [1:0] CMD_WRITE   = 2'd1;
	localparam logic [1:0] CMD_READ    = 2'd2;
	localparam logic [1:0] CMD_RELEASE = 2'd3;

	// Converter config bytes: start bit, continuous mode, 16-bit rate, gain.
	localparam logic [7:0] CFG_VOLTAGE   = 8'h84;
	localparam logic [7:0] CFG_CURRENT   = 8'h87;
	localparam int         NOT_READY_BIT = 7;

	localparam logic [2:0] STEP_V_CFG   = 3'd0;
	localparam logic [2:0] STEP_V_ISSUE = 3'd1;
	localparam logic [2:0] STEP_V_WAIT  = 3'd2;
	localparam logic [2:0] STEP_C_CFG   = 3'd3;
	localparam logic [2:0] STEP_C_ISSUE = 3'd4;
	localparam logic [2:0] STEP_C_WAIT  = 3'd5;

	typedef struct packed {
		logic       transfer_done;
		logic [7:0] rx_high_byte;
		logic [7:0] rx_low_byte;
		logic [7:0] rx_status_byte;
	} tick_item_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  command_byte;
		logic        mux_select;
		logic [15:0] voltage_counts;
		logic [15:0] current_counts;
		logic        pair_ready;
		logic        fault;
	} result_item_t;

	typedef struct packed {
		logic        man_v_en;
		logic [15:0] man_v_val;
		logic        man_c_en;
		logic [15:0] man_c_val;
	} manual_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/apss_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apss_core: scan step state and per-item update
// Holds the step, mux level and stored counts, and forms the result of the
// item presented on advance.
// ----------------------------------------------------------------------------
module apss_core import apss_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         advance,
	input  wire tick_item_t   item,
	input  wire manual_cfg_t  man_cfg,
	output result_item_t      result
);

	logic [2:0]  step_q, step_d;
	logic        mux_q, mux_d;
	logic [15:0] volt_q, volt_d;
	logic [15:0] curr_q, curr_d;
	logic [15:0] sample;
	logic        not_ready;
	logic [1:0]  cmd;
	logic [7:0]  cbyte;
	logic        ready;
	logic        fault;

	assign sample    = {item.rx_high_byte, item.rx_low_byte};
	assign not_ready = item.rx_status_byte[NOT_READY_BIT];

	always_comb begin
		step_d = step_q;
		mux_d  = mux_q;
		volt_d = volt_q;
		curr_d = curr_q;
		cmd    = CMD_NONE;
		cbyte  = 8'h00;
		ready  = 1'b0;
		fault  = 1'b0;
		case (step_q)
			STEP_V_CFG: begin
				mux_d  = 1'b0;
				cmd    = CMD_WRITE;
				cbyte  = CFG_VOLTAGE;
				step_d = STEP_V_ISSUE;
			end
			STEP_C_CFG: begin
				mux_d  = 1'b1;
				cmd    = CMD_WRITE;
				cbyte  = CFG_CURRENT;
				step_d = STEP_C_ISSUE;
			end
			STEP_V_ISSUE: begin
				if (item.transfer_done) begin
					cmd    = CMD_READ;
					step_d = STEP_V_WAIT;
				end
			end
			STEP_C_ISSUE: begin
				if (item.transfer_done) begin
					cmd    = CMD_READ;
					step_d = STEP_C_WAIT;
				end
			end
			STEP_V_WAIT: begin
				if (item.transfer_done) begin
					if (not_ready) begin
						step_d = STEP_V_ISSUE;
					end else begin
						volt_d = man_cfg.man_v_en ? man_cfg.man_v_val : sample;
						step_d = STEP_C_CFG;
					end
				end
			end
			STEP_C_WAIT: begin
				if (item.transfer_done) begin
					if (not_ready) begin
						step_d = STEP_C_ISSUE;
					end else begin
						curr_d = man_cfg.man_c_en ? man_cfg.man_c_val : sample;
						ready  = 1'b1;
						cmd    = CMD_RELEASE;
						step_d = STEP_V_CFG;
					end
				end
			end
			default: begin
				fault  = 1'b1;
				step_d = STEP_V_CFG;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_V_CFG;
			mux_q  <= 1'b0;
			volt_q <= '0;
			curr_q <= '0;
		end else if (advance) begin
			step_q <= step_d;
			mux_q  <= mux_d;
			volt_q <= volt_d;
			curr_q <= curr_d;
		end
	end

	always_comb begin
		result.command        = cmd;
		result.command_byte   = cbyte;
		result.mux_select     = mux_d;
		result.voltage_counts = volt_d;
		result.current_counts = curr_d;
		result.pair_ready     = ready;
		result.fault          = fault;
	end

endmodule

`default_nettype wire

FILE: rtl/adc_pair_scan_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adc_pair_scan_sequencer: paired voltage/current converter scan controller
// Each poll tick item steps the sequencer once and yields one result item.
// ----------------------------------------------------------------------------
// Usage: one tick item is accepted per clock and each produces exactly one
// result item. The item goes into an input register, and the step update then
// writes the result register once the output side is free, which raises
// result_valid. Throughput is one item per cycle, limited only by
// result_stall. While a result waits, the input register can still take one
// more item; tick_stall rises only when both registers are full. The user
// must write the manual override registers through cfg_we/cfg_index/cfg_data
// only while no items are in flight; the block does not enforce this.
module adc_pair_scan_sequencer import apss_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   tick_valid,
	output logic                        tick_stall,
	input  wire tick_item_t             tick,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output result_item_t                result
);

	manual_cfg_t  cfg_q;
	logic         valid_s1;
	tick_item_t   item_s1;
	logic         valid_q;
	result_item_t result_q;
	result_item_t result_d;
	logic         out_free;
	logic         advance;
	logic         take_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAN_V_EN:  cfg_q.man_v_en  <= cfg_data[0];
				REG_MAN_V_VAL: cfg_q.man_v_val <= cfg_data;
				REG_MAN_C_EN:  cfg_q.man_c_en  <= cfg_data[0];
				REG_MAN_C_VAL: cfg_q.man_c_val <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_free   = !valid_q || !result_stall;
	assign advance    = valid_s1 && out_free;
	assign tick_stall = valid_s1 && !out_free;
	assign take_in    = tick_valid && !tick_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= tick;
		end
	end

	apss_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.man_cfg (cfg_q),
		.result  (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

`ifndef NO_ASSERTIONS
	// The step register only ever holds the six scan steps.
	a_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		!(result_valid && result.fault))
		else $error("scan step left its legal range");

	a_pair_release: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.pair_ready) |-> (result.command == CMD_RELEASE))
		else $error("pair_ready without bus release");

	a_cfg_byte_mux: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.command == CMD_WRITE) |->
		((result.command_byte == CFG_VOLTAGE && !result.mux_select) ||
		 (result.command_byte == CFG_CURRENT && result.mux_select)))
		else $error("config byte does not match mux select");

	a_accept_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !tick_stall)
		else $error("input stalled while result register is empty");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for adc_pair_scan_sequencer
// Poll tick items are sent in random bursts while the result side stalls on
// its own pattern. A scoreboard mirrors the scan steps, mux level, stored
// counts and manual overrides, and checks each result item field by field.
// Directed tick items run under the first override setting, then random ones
// run under each of the six settings.
// ----------------------------------------------------------------------------
import apss_pkg::*;

class pair_scoreboard;
	logic [2:0]   scan_step;
	logic         mux_level;
	logic [15:0]  voltage_store;
	logic [15:0]  current_store;
	manual_cfg_t  manual;
	result_item_t due_results[$];
	int           failures;
	int           tick_count;
	int           pair_count;
	int           retry_count;
	int           override_count;

	function new();
		scan_step = STEP_V_CFG;
		mux_level = 1'b0;
		voltage_store = '0;
		current_store = '0;
		manual = '0;
		failures = 0;
		tick_count = 0;
		pair_count = 0;
		retry_count = 0;
		override_count = 0;
	endfunction

	function void report(string msg);
		// Keep the log readable if the block is badly broken.
		if (failures < 100)
			$display("MISMATCH at %0t: %s", $time, msg);
		failures++;
	endfunction

	function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_MAN_V_EN:  manual.man_v_en = data[0];
			REG_MAN_V_VAL: manual.man_v_val = data;
			REG_MAN_C_EN:  manual.man_c_en = data[0];
			REG_MAN_C_VAL: manual.man_c_val = data;
			default: ;
		endcase
	endfunction

	// Advances the scan by one poll tick and returns the result it should give.
	function result_item_t step_scan(tick_item_t t);
		result_item_t r;
		logic [15:0]  sample;
		logic         not_ready;
		r = '0;
		sample = {t.rx_high_byte, t.rx_low_byte};
		not_ready = t.rx_status_byte[NOT_READY_BIT];
		r.command = CMD_NONE;
		case (scan_step)
			STEP_V_CFG, STEP_C_CFG: begin
				mux_level = (scan_step == STEP_C_CFG);
				r.command = CMD_WRITE;
				r.command_byte = (scan_step == STEP_C_CFG) ? CFG_CURRENT : CFG_VOLTAGE;
				scan_step = scan_step + 3'd1;
			end
			STEP_V_ISSUE, STEP_C_ISSUE: begin
				if (t.transfer_done) begin
					r.command = CMD_READ;
					scan_step = scan_step + 3'd1;
				end
			end
			STEP_V_WAIT: begin
				if (t.transfer_done && not_ready) begin
					retry_count++;
					scan_step = STEP_V_ISSUE;
				end else if (t.transfer_done) begin
					if (manual.man_v_en)
						override_count++;
					voltage_store = manual.man_v_en ? manual.man_v_val : sample;
					scan_step = STEP_C_CFG;
				end
			end
			STEP_C_WAIT: begin
				if (t.transfer_done && not_ready) begin
					retry_count++;
					scan_step = STEP_C_ISSUE;
				end else if (t.transfer_done) begin
					if (manual.man_c_en)
						override_count++;
					current_store = manual.man_c_en ? manual.man_c_val : sample;
					r.pair_ready = 1'b1;
					r.command = CMD_RELEASE;
					pair_count++;
					scan_step = STEP_V_CFG;
				end
			end
			default: begin
				r.fault = 1'b1;
				scan_step = STEP_V_CFG;
			end
		endcase
		r.mux_select = mux_level;
		r.voltage_counts = voltage_store;
		r.current_counts = current_store;
		return r;
	endfunction

	function void note_tick(tick_item_t t);
		tick_count++;
		due_results.push_back(step_scan(t));
	endfunction

	function void compare(string field, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report($sformatf("%s is %h, expected %h", field, got, want));
	endfunction

	function void check_result(result_item_t got);
		result_item_t want;
		if (due_results.size() == 0) begin
			report("result item arrived with nothing expected");
			return;
		end
		want = due_results.pop_front();
		compare("command", 16'(got.command), 16'(want.command));
		compare("command_byte", 16'(got.command_byte), 16'(want.command_byte));
		compare("mux_select", 16'(got.mux_select), 16'(want.mux_select));
		compare("voltage_counts", got.voltage_counts, want.voltage_counts);
		compare("current_counts", got.current_counts, want.current_counts);
		compare("pair_ready", 16'(got.pair_ready), 16'(want.pair_ready));
		compare("fault", 16'(got.fault), 16'(want.fault));
	endfunction

	function int pending();
		return due_results.size();
	endfunction
endclass

module tb_top;
	localparam int N_PHASES = 6;
	localparam int RANDOM_PER_PHASE = 230;

	// Walks a full pair with stalled transfers and not-ready retries on both
	// channels, using all-zero and all-one bytes and the ready bit boundaries.
	localparam tick_item_t DIRECTED_TICKS [20] = '{
		'{1'b0, 8'h00, 8'h00, 8'h00},
		'{1'b0, 8'hFF, 8'hFF, 8'hFF},
		'{1'b1, 8'h00, 8'h00, 8'h00},
		'{1'b0, 8'h12, 8'h34, 8'h00},
		'{1'b1, 8'hFF, 8'hFF, 8'h80},
		'{1'b1, 8'h00, 8'h00, 8'hFF},
		'{1'b1, 8'hFF, 8'hFF, 8'h7F},
		'{1'b1, 8'hAA, 8'h55, 8'hFF},
		'{1'b0, 8'h00, 8'h00, 8'h00},
		'{1'b1, 8'h00, 8'h00, 8'h00},
		'{1'b1, 8'h12, 8'h34, 8'hFF},
		'{1'b1, 8'h00, 8'h00, 8'h00},
		'{1'b0, 8'hFF, 8'hFF, 8'h00},
		'{1'b1, 8'h00, 8'h00, 8'h00},
		'{1'b1, 8'h80, 8'h01, 8'h7F},
		'{1'b1, 8'h55, 8'hAA, 8'h80},
		'{1'b1, 8'h80, 8'h01, 8'h00},
		'{1'b1, 8'h00, 8'h00, 8'h00},
		'{1'b1, 8'h00, 8'h00, 8'h00},
		'{1'b1, 8'h7F, 8'hFE, 8'h01}
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   tick_valid = 1'b0;
	logic                   tick_stall;
	tick_item_t             tick = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	result_item_t           result;

	pair_scoreboard sb = new();
	int             burst_left = 0;
	logic [9:0]     stall_count = '0;

	adc_pair_scan_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.tick_valid(tick_valid),
		.tick_stall(tick_stall),
		.tick(tick),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #5 clk = ~clk;

	// The receiver cycles through free flow, random stalls, a short periodic
	// stall and a longer periodic stall.
	always @(posedge clk) begin
		stall_count <= stall_count + 10'd1;
		case (stall_count[9:8])
			2'd0: result_stall <= 1'b0;
			2'd1: result_stall <= ($urandom_range(0, 9) < 3);
			2'd2: result_stall <= (stall_count[2:0] < 3'd3);
			default: result_stall <= (stall_count[5:3] == 3'd5);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_valid && !tick_stall)
				sb.note_tick(tick);
			if (result_valid && !result_stall)
				sb.check_result(result);
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	// Called at a rising edge; returns at the edge where the item is taken.
	task automatic send_tick(input tick_item_t item);
		if (burst_left == 0) begin
			tick_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
		tick_valid <= 1'b1;
		tick <= item;
		do @(posedge clk); while (tick_stall);
		burst_left--;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Mostly completed transfers so the scan keeps moving, with a share of
	// not-ready status and some fully random items.
	function automatic tick_item_t random_tick();
		tick_item_t t;
		if ($urandom_range(0, 9) == 0) begin
			t = $bits(tick_item_t)'($urandom);
		end else begin
			t.transfer_done = ($urandom_range(0, 9) != 0);
			t.rx_high_byte = pick_byte();
			t.rx_low_byte = pick_byte();
			t.rx_status_byte = {($urandom_range(0, 3) == 0), 7'($urandom)};
		end
		return t;
	endfunction

	initial begin
		int          phase;
		logic        v_en;
		logic        c_en;
		logic [15:0] v_val;
		logic [15:0] c_val;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (phase = 0; phase < N_PHASES; phase++) begin
			v_en = 1'($urandom_range(0, 1));
			c_en = 1'($urandom_range(0, 1));
			v_val = 16'($urandom);
			c_val = 16'($urandom);
			case (phase)
				0: begin
					v_en = 1'b0;
					c_en = 1'b0;
					v_val = 16'h0000;
					c_val = 16'h0000;
				end
				1: begin
					v_en = 1'b1;
					c_en = 1'b1;
					v_val = 16'hFFFF;
					c_val = 16'h0000;
				end
				2: begin
					v_en = 1'b1;
					c_en = 1'b1;
					v_val = 16'h0000;
					c_val = 16'hFFFF;
				end
				3: begin
					v_en = 1'b0;
					c_en = 1'b1;
				end
				4: begin
					v_en = 1'b1;
					c_en = 1'b0;
				end
				default: ;
			endcase
			// Enable registers only use bit 0; the upper bits get noise.
			write_reg(REG_MAN_V_EN, {15'($urandom), v_en});
			write_reg(REG_MAN_V_VAL, v_val);
			write_reg(REG_MAN_C_EN, {15'($urandom), c_en});
			write_reg(REG_MAN_C_VAL, c_val);
			cfg_we <= 1'b0;
			@(posedge clk);
			if (phase == 0) begin
				foreach (DIRECTED_TICKS[i])
					send_tick(DIRECTED_TICKS[i]);
			end
			repeat (RANDOM_PER_PHASE)
				send_tick(random_tick());
			// Hold the sender until every result has come back.
			tick_valid <= 1'b0;
			do @(posedge clk); while (sb.pending() != 0);
			repeat (3) @(posedge clk);
		end
		repeat (8) @(posedge clk);
		$display("Ran %0d poll ticks under %0d override settings: %0d pairs completed,",
			sb.tick_count, N_PHASES, sb.pair_count);
		$display("%0d not-ready retries and %0d override stores.",
			sb.retry_count, sb.override_count);
		if (sb.failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("Timeout waiting for the scan sequencer.");
		$display("Test completed with failures");
		$finish;
	end
endmodule

FILE: sim.f
rtl/apss_pkg.sv
rtl/apss_core.sv
rtl/adc_pair_scan_sequencer.sv
tb/tb_top.sv
